/* hdl/ptt_pkg.sv */
// ----------------------------------------------------------------------------
// ptt_pkg
// Types and constants shared by the periodic task timer table.
// ----------------------------------------------------------------------------
package ptt_pkg;

	// most ready ids reported by one collect
	localparam int MAX_RESULTS = 8;
	localparam int KW          = $clog2(MAX_RESULTS + 1);

	// operation codes
	typedef enum logic [1:0] {
		OP_TICK    = 2'd0,
		OP_ADD     = 2'd1,
		OP_REMOVE  = 2'd2,
		OP_COLLECT = 2'd3
	} op_t;

	// result status codes
	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_NULL     = 3'd1,
		ST_DUP      = 3'd2,
		ST_FULL     = 3'd3,
		ST_NOTFOUND = 3'd4
	} status_t;

	// sequencer states
	typedef enum logic [1:0] {
		S_IDLE,
		S_WALK,
		S_FIN
	} state_t;

	// request item
	typedef struct packed {
		op_t         func;
		logic [7:0]  task_id;
		logic [15:0] period;
		logic [15:0] start_count;
		logic        start_pending;
	} req_t;

	// result item
	typedef struct packed {
		status_t    status;
		logic       ready_valid;
		logic [7:0] ready_id;
		logic       last;
	} rsp_t;

	// one timer entry as stored in the slot memory
	typedef struct packed {
		logic [7:0]  id;
		logic [15:0] period;
		logic [15:0] count;
		logic        pending;
	} slot_t;

endpackage

/* hdl/ptt_ram.sv */
// ----------------------------------------------------------------------------
// ptt_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module ptt_ram #(
	parameter int WIDTH = 41,
	parameter int DEPTH = 8,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read, data holds while rd_en is low
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

/* hdl/periodic_task_timer_table_core.sv */
// ----------------------------------------------------------------------------
// periodic_task_timer_table_core
// Table of periodic task timers kept in insertion order in one slot RAM.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid / req_stall / req) carries one operation item:
//   tick, add, remove or collect. rsp channel (rsp_valid / rsp_stall / rsp)
//   returns result items; every operation ends with an item whose last is 1.
//   One item is handled at a time; req_stall is high from acceptance until
//   the final result is loaded into the output register.
// Sequencing:
//   tick, collect and a non-null add or remove walk the n used slots through
//   the registered slot RAM read port, one slot a cycle while collect is not
//   paused by a stalled output, then finish in the S_FIN state. A null add or
//   remove skips the walk and goes straight to S_FIN. Collect emits up to
//   MAX_RESULTS items, one per pending timer.
// Reset:
//   arst_n clears the fill count, so the table starts empty; the RAM itself
//   is not cleared, only used slots are ever read.
// Stall:
//   a stalled result holds in the output register; during collect the walk
//   pauses while the output register cannot take a new item.
// ----------------------------------------------------------------------------
module periodic_task_timer_table_core
	import ptt_pkg::*;
#(
	parameter int SLOTS = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = $clog2(SLOTS + 1);

	state_t state_q, state_d;

	// operation registers
	op_t         op_q;
	logic [7:0]  id_q;
	logic [15:0] per_q;
	logic [15:0] cnt_q;
	logic        pend_q;

	// walk registers
	logic [CW-1:0] n_q;
	logic [CW-1:0] rd_idx_q;
	logic          s1_valid_q;
	logic [AW-1:0] s1_idx_q;
	logic          found_q;
	logic          held_valid_q;
	logic [7:0]    held_id_q;
	logic [KW-1:0] k_q;

	// output register
	logic out_valid_q;
	rsp_t out_q;

	// ram port
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	slot_t         rd_data;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	slot_t         wr_data;

	// control
	logic        out_free;
	logic        freeze;
	logic        walk_run;
	logic        proc;
	logic        walk_done;
	logic        fin_go;
	logic        match;
	logic        take;
	logic        add_ok;
	logic        push;
	rsp_t        push_item;
	logic [15:0] cnt_inc;

	ptt_ram #(
		.WIDTH ($bits(slot_t)),
		.DEPTH (SLOTS),
		.AW    (AW)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// walk status
	assign out_free  = !out_valid_q || !rsp_stall;
	assign freeze    = (op_q == OP_COLLECT) && !out_free;
	assign walk_run  = (state_q == S_WALK) && !freeze;
	assign proc      = walk_run && s1_valid_q;
	assign walk_done = (state_q == S_WALK) && (rd_idx_q == n_q) && !s1_valid_q;
	assign fin_go    = (state_q == S_FIN) && out_free;
	assign match     = s1_valid_q && (rd_data.id == id_q);
	assign take      = proc && rd_data.pending && (k_q < KW'(MAX_RESULTS));
	assign add_ok    = (id_q != 8'd0) && !found_q && (n_q != CW'(SLOTS));
	assign cnt_inc   = rd_data.count + 16'd1;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					if ((req.func == OP_ADD || req.func == OP_REMOVE) && req.task_id == 8'd0) begin
						state_d = S_FIN;
					end else begin
						state_d = S_WALK;
					end
				end
			end
			S_WALK: begin
				if (walk_done) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// outputs: handshake, ram access and result push
	always_comb begin
		req_stall = (state_q != S_IDLE);
		rd_en     = walk_run && (rd_idx_q < n_q);
		rd_addr   = rd_idx_q[AW-1:0];
		wr_en     = 1'b0;
		wr_addr   = s1_idx_q;
		wr_data   = rd_data;
		push      = 1'b0;
		push_item = '{status: ST_OK, ready_valid: 1'b0, ready_id: 8'd0, last: 1'b1};
		case (op_q)
			OP_TICK: begin
				if (proc) begin
					wr_en = 1'b1;
					if (cnt_inc >= rd_data.period) begin
						wr_data.count   = 16'd0;
						wr_data.pending = 1'b1;
					end else begin
						wr_data.count = cnt_inc;
					end
				end
			end
			OP_ADD: begin
				if (fin_go) begin
					wr_en   = add_ok;
					wr_addr = n_q[AW-1:0];
					wr_data = '{id: id_q, period: per_q, count: cnt_q, pending: pend_q};
					if (id_q == 8'd0) begin
						push_item.status = ST_NULL;
					end else if (found_q) begin
						push_item.status = ST_DUP;
					end else if (n_q == CW'(SLOTS)) begin
						push_item.status = ST_FULL;
					end
				end
			end
			OP_REMOVE: begin
				// slots after the match move up by one
				if (proc && found_q) begin
					wr_en   = 1'b1;
					wr_addr = s1_idx_q - AW'(1);
				end
				if (id_q == 8'd0) begin
					push_item.status = ST_NULL;
				end else if (!found_q) begin
					push_item.status = ST_NOTFOUND;
				end
			end
			OP_COLLECT: begin
				if (take) begin
					wr_en           = 1'b1;
					wr_data.pending = 1'b0;
				end
				// a held id goes out once another one is found
				if (take && held_valid_q) begin
					push      = 1'b1;
					push_item = '{status: ST_OK, ready_valid: 1'b1, ready_id: held_id_q,
						last: 1'b0};
				end else if (held_valid_q) begin
					push_item = '{status: ST_OK, ready_valid: 1'b1, ready_id: held_id_q,
						last: 1'b1};
				end
			end
			default: ;
		endcase
		if (fin_go) begin
			push = 1'b1;
		end
	end

	// state and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			n_q     <= '0;
		end else begin
			state_q <= state_d;
			if (fin_go && op_q == OP_ADD && add_ok) begin
				n_q <= n_q + CW'(1);
			end else if (fin_go && op_q == OP_REMOVE && found_q) begin
				n_q <= n_q - CW'(1);
			end
		end
	end

	// walk control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q     <= '0;
			s1_valid_q   <= 1'b0;
			found_q      <= 1'b0;
			held_valid_q <= 1'b0;
			k_q          <= '0;
		end else if (state_q == S_IDLE && req_valid) begin
			rd_idx_q     <= '0;
			s1_valid_q   <= 1'b0;
			found_q      <= 1'b0;
			held_valid_q <= 1'b0;
			k_q          <= '0;
		end else if (walk_run) begin
			s1_valid_q <= rd_en;
			if (rd_en) begin
				rd_idx_q <= rd_idx_q + CW'(1);
			end
			if (proc && match) begin
				found_q <= 1'b1;
			end
			if (op_q == OP_COLLECT && take) begin
				held_valid_q <= 1'b1;
				k_q          <= k_q + KW'(1);
			end
		end
	end

	// operation and walk payload
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req_valid) begin
			op_q   <= req.func;
			id_q   <= req.task_id;
			per_q  <= req.period;
			cnt_q  <= req.start_count;
			pend_q <= req.start_pending;
		end
		if (walk_run) begin
			s1_idx_q <= rd_idx_q[AW-1:0];
			if (op_q == OP_COLLECT && take) begin
				held_id_q <= rd_data.id;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push) begin
			out_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			out_q <= push_item;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

endmodule

/* hdl/ptt_checker.sv */
// ----------------------------------------------------------------------------
// ptt_checker
// Port-level checks for the periodic task timer table, bound to the core.
// ----------------------------------------------------------------------------
module ptt_checker
	import ptt_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_stall,
	input req_t req,
	input logic rsp_valid,
	input logic rsp_stall,
	input rsp_t rsp
);

	// a stalled result item holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("result item changed while stalled");

	// one item at a time: busy right after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("item accepted while previous one in flight");

	// only ready ids can be followed by more results
	a_plain_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.ready_valid |-> rsp.last)
		else $error("non-ready result not marked last");

	// a reported id is a real task and carries ok status
	a_ready_id: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.ready_valid |-> rsp.status == ST_OK && rsp.ready_id != 8'd0)
		else $error("bad ready item");

endmodule

bind periodic_task_timer_table_core ptt_checker u_ptt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Random and directed test of the periodic task timer table: a queue-fed
// driver offers tick, add, remove and collect items, a behavioral copy of the
// table works out the result items, and a monitor checks each one in order.
// ----------------------------------------------------------------------------
module tb_top;
	import ptt_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS      = 8;
	localparam int RAND_OPS   = 400;
	localparam int CYCLE_CAP  = 1000000;
	localparam int TAIL_WAIT  = 40;
	localparam int MAX_REPORT = 40;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	periodic_task_timer_table_core #(.SLOTS(SLOTS)) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	// items waiting to be offered, result items still owed by the table
	req_t op_queue[$];
	rsp_t outcome_q[$];

	// shadow copy of the timer table
	logic [7:0]  tm_id      [SLOTS];
	logic [15:0] tm_period  [SLOTS];
	logic [15:0] tm_count   [SLOTS];
	logic        tm_pending [SLOTS];
	int          tm_fill;

	int mismatches = 0;
	int ops_taken  = 0;
	int cycles     = 0;

	// clock
	initial begin
		forever #2 clk = ~clk;
	end

	// position of a task id in the shadow table, -1 if absent
	function automatic int slot_of(logic [7:0] id);
		for (int i = 0; i < tm_fill; i++)
			if (tm_id[i] == id)
				return i;
		return -1;
	endfunction

	// apply one item to the shadow table and queue the result items it causes
	task automatic timer_table_step(input req_t r);
		rsp_t        o;
		int          pos;
		int          k;
		logic [7:0]  due_ids [MAX_RESULTS];
		logic [15:0] nxt;
		o.status      = ST_OK;
		o.ready_valid = 1'b0;
		o.ready_id    = 8'd0;
		o.last        = 1'b1;
		case (r.func)
			OP_TICK: begin
				for (int i = 0; i < tm_fill; i++) begin
					nxt = tm_count[i] + 16'd1;
					if (nxt >= tm_period[i]) begin
						tm_pending[i] = 1'b1;
						nxt = 16'd0;
					end
					tm_count[i] = nxt;
				end
				outcome_q.push_back(o);
			end
			OP_ADD: begin
				if (r.task_id == 8'd0)
					o.status = ST_NULL;
				else if (slot_of(r.task_id) >= 0)
					o.status = ST_DUP;
				else if (tm_fill >= SLOTS)
					o.status = ST_FULL;
				else begin
					tm_id[tm_fill]      = r.task_id;
					tm_period[tm_fill]  = r.period;
					tm_count[tm_fill]   = r.start_count;
					tm_pending[tm_fill] = r.start_pending;
					tm_fill++;
				end
				outcome_q.push_back(o);
			end
			OP_REMOVE: begin
				pos = slot_of(r.task_id);
				if (r.task_id == 8'd0)
					o.status = ST_NULL;
				else if (pos < 0)
					o.status = ST_NOTFOUND;
				else begin
					// later entries move up one place
					for (int i = pos; i < tm_fill - 1; i++) begin
						tm_id[i]      = tm_id[i + 1];
						tm_period[i]  = tm_period[i + 1];
						tm_count[i]   = tm_count[i + 1];
						tm_pending[i] = tm_pending[i + 1];
					end
					tm_fill--;
				end
				outcome_q.push_back(o);
			end
			default: begin
				// collect: pending ids in table order, marks cleared
				k = 0;
				for (int i = 0; i < tm_fill; i++) begin
					if (tm_pending[i] && k < MAX_RESULTS) begin
						tm_pending[i] = 1'b0;
						due_ids[k] = tm_id[i];
						k++;
					end
				end
				if (k == 0)
					outcome_q.push_back(o);
				for (int j = 0; j < k; j++) begin
					o.ready_valid = 1'b1;
					o.ready_id    = due_ids[j];
					o.last        = (j == k - 1);
					outcome_q.push_back(o);
				end
			end
		endcase
	endtask

	function automatic req_t mk_op(op_t f, logic [7:0] id, logic [15:0] per,
			logic [15:0] cnt, logic pend);
		req_t r;
		r.func          = f;
		r.task_id       = id;
		r.period        = per;
		r.start_count   = cnt;
		r.start_pending = pend;
		return r;
	endfunction

	// random item: small id pool so that duplicates, removes and a full table occur
	function automatic req_t rand_op();
		req_t        r;
		int unsigned w;
		w = $urandom_range(0, 99);
		if (w < 35)
			r.func = OP_TICK;
		else if (w < 62)
			r.func = OP_ADD;
		else if (w < 80)
			r.func = OP_REMOVE;
		else
			r.func = OP_COLLECT;
		w = $urandom_range(0, 99);
		if (w < 4)
			r.task_id = 8'd0;
		else if (w < 14)
			r.task_id = 8'($urandom);
		else
			r.task_id = 8'($urandom_range(1, 12));
		r.period        = ($urandom_range(0, 9) < 8) ? 16'($urandom_range(0, 6))
			: 16'($urandom);
		r.start_count   = ($urandom_range(0, 9) < 8) ? 16'($urandom_range(0, 4))
			: 16'($urandom);
		r.start_pending = 1'($urandom_range(0, 1));
		return r;
	endfunction

	// idle length: mostly none or short, now and then long
	function automatic int idle_len();
		int unsigned w;
		w = $urandom_range(0, 99);
		if (w < 55)
			return 0;
		else if (w < 85)
			return $urandom_range(1, 3);
		else if (w < 97)
			return $urandom_range(4, 12);
		else
			return $urandom_range(20, 60);
	endfunction

	// driver
	logic drv_valid;
	req_t drv_item;
	int   gap_left   = 0;
	int   drv_steady = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req       <= '0;
		end else begin
			drv_valid = req_valid;
			drv_item  = req;
			if (req_valid && !req_stall) begin
				timer_table_step(req);
				ops_taken++;
				drv_valid = 1'b0;
			end
			if (!drv_valid) begin
				if (gap_left > 0)
					gap_left--;
				else if (op_queue.size() != 0) begin
					drv_item  = op_queue.pop_front();
					drv_valid = 1'b1;
					// stretches with no gaps between items
					if (drv_steady > 0) begin
						drv_steady--;
						gap_left = 0;
					end else if ($urandom_range(0, 39) == 0) begin
						drv_steady = $urandom_range(10, 30);
						gap_left   = 0;
					end else
						gap_left = idle_len();
				end
			end
			req_valid <= drv_valid;
			req       <= drv_item;
		end
	end

	task automatic report(string field, int want, int got);
		mismatches++;
		if (mismatches <= MAX_REPORT)
			$display("%0t: %s expected %0d actual %0d", $time, field, want, got);
	endtask

	// monitor and receiver stalls
	rsp_t mon_want;
	int   hold_left  = 0;
	int   mon_steady = 0;
	bit   pressed    = 1'b0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (outcome_q.size() == 0)
					report("unexpected item, ready_id", 0, rsp.ready_id);
				else begin
					mon_want = outcome_q.pop_front();
					if (rsp.status != mon_want.status)
						report("status", mon_want.status, rsp.status);
					if (rsp.ready_valid != mon_want.ready_valid)
						report("ready_valid", mon_want.ready_valid, rsp.ready_valid);
					if (rsp.ready_id != mon_want.ready_id)
						report("ready_id", mon_want.ready_id, rsp.ready_id);
					if (rsp.last != mon_want.last)
						report("last", mon_want.last, rsp.last);
				end
			end
			// one long hold-off so the table backs up into the request side
			if (!pressed && ops_taken >= 40) begin
				pressed   = 1'b1;
				hold_left = 150;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= 1'b0;
				if (mon_steady > 0)
					mon_steady--;
				else if ($urandom_range(0, 49) == 0)
					mon_steady = $urandom_range(10, 40);
				else if ($urandom_range(0, 3) == 0)
					hold_left = idle_len();
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_CAP) begin
			$display("tb_top failed");
			$finish;
		end
	end

	// stimulus and end of run
	initial begin
		// empty table cases
		op_queue.push_back(mk_op(OP_COLLECT, 8'd0, 16'd0, 16'd0, 1'b0));
		op_queue.push_back(mk_op(OP_TICK, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b1));
		op_queue.push_back(mk_op(OP_REMOVE, 8'd5, 16'd0, 16'd0, 1'b0));
		op_queue.push_back(mk_op(OP_REMOVE, 8'd0, 16'd0, 16'd0, 1'b0));
		op_queue.push_back(mk_op(OP_ADD, 8'd0, 16'd5, 16'd0, 1'b0));
		// fill the table, field extremes, duplicate id, then a full table
		op_queue.push_back(mk_op(OP_ADD, 8'hFF, 16'd0, 16'd0, 1'b0));
		op_queue.push_back(mk_op(OP_ADD, 8'd1, 16'hFFFF, 16'hFFFF, 1'b1));
		op_queue.push_back(mk_op(OP_ADD, 8'hFF, 16'd7, 16'd1, 1'b0));
		op_queue.push_back(mk_op(OP_ADD, 8'hAA, 16'hAAAA, 16'h5555, 1'b0));
		op_queue.push_back(mk_op(OP_ADD, 8'h55, 16'h5555, 16'hAAAA, 1'b1));
		op_queue.push_back(mk_op(OP_ADD, 8'd2, 16'd1, 16'd0, 1'b0));
		op_queue.push_back(mk_op(OP_ADD, 8'd3, 16'd2, 16'd1, 1'b0));
		op_queue.push_back(mk_op(OP_ADD, 8'd4, 16'd10, 16'd9, 1'b0));
		op_queue.push_back(mk_op(OP_ADD, 8'd5, 16'd100, 16'd0, 1'b1));
		op_queue.push_back(mk_op(OP_ADD, 8'd6, 16'd1, 16'd0, 1'b0));
		// tick and collect on a full table, count wrap, period zero
		op_queue.push_back(mk_op(OP_TICK, 8'd0, 16'd0, 16'd0, 1'b0));
		op_queue.push_back(mk_op(OP_COLLECT, 8'd9, 16'd1, 16'd1, 1'b1));
		op_queue.push_back(mk_op(OP_COLLECT, 8'd0, 16'd0, 16'd0, 1'b0));
		op_queue.push_back(mk_op(OP_TICK, 8'd0, 16'd0, 16'd0, 1'b0));
		op_queue.push_back(mk_op(OP_COLLECT, 8'd0, 16'd0, 16'd0, 1'b0));
		// removes from middle, end and front, then a stale id
		op_queue.push_back(mk_op(OP_REMOVE, 8'd1, 16'hFFFF, 16'hFFFF, 1'b1));
		op_queue.push_back(mk_op(OP_REMOVE, 8'd5, 16'd0, 16'd0, 1'b0));
		op_queue.push_back(mk_op(OP_REMOVE, 8'hFF, 16'd0, 16'd0, 1'b0));
		op_queue.push_back(mk_op(OP_REMOVE, 8'd1, 16'd0, 16'd0, 1'b0));
		op_queue.push_back(mk_op(OP_COLLECT, 8'd0, 16'd0, 16'd0, 1'b0));
		for (int n = 0; n < RAND_OPS; n++)
			op_queue.push_back(rand_op());

		repeat (4) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// drain everything, then let the block settle
		do
			@(negedge clk);
		while (op_queue.size() != 0 || req_valid || outcome_q.size() != 0);
		repeat (TAIL_WAIT) @(negedge clk);
		if (mismatches == 0 && outcome_q.size() == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule
